[hdl/dss_pkg.sv]
// Shared constants and types for the dashed segment splitter.
// No dependencies; used by dashed_segment_splitter.
`timescale 1ns / 1ps

package dss_pkg;

   localparam int COORD_W = 32;
   localparam int CFG_W   = 24;
   localparam int IDX_W   = 2;

   // register indexes on the csr port
   localparam logic [IDX_W-1:0] CSR_DASH_LENGTH = 2'd0;
   localparam logic [IDX_W-1:0] CSR_DASH_GAP    = 2'd1;

   localparam logic [CFG_W-1:0] DASH_LENGTH_RST = 24'd9830;
   localparam logic [CFG_W-1:0] DASH_GAP_RST    = 24'd29491;

   // shared compare-subtract unit
   localparam int STEP_W = 38;

   typedef struct packed {
      logic [STEP_W:0] diff;
      logic            ge;
   } step_type;

endpackage

[hdl/dashed_segment_splitter.sv]
// Dashed segment splitter: cuts a 3D line into dashes centred on its midpoint.
// Uses dss_pkg. Per item: squares, square root, a check, modulo and phase set-up, then a walk
// step per segment and, per dash, a load, divide and multiply/add for each of its two endpoints,
// all on one shared subtract unit and one 33x33 multiplier.
// A dash is held until the next is found, and busy drops as the last leaves. Reset is synchronous.
`timescale 1ns / 1ps

module dashed_segment_splitter #(
   parameter int MAX_DASHES = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [dss_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [dss_pkg::COORD_W-1:0]  req_start_y,
   input  logic signed [dss_pkg::COORD_W-1:0]  req_start_z,
   input  logic signed [dss_pkg::COORD_W-1:0]  req_finish_x,
   input  logic signed [dss_pkg::COORD_W-1:0]  req_finish_y,
   input  logic signed [dss_pkg::COORD_W-1:0]  req_finish_z,
   output logic                                rsp_valid,
   output logic signed [dss_pkg::COORD_W-1:0]  rsp_dash_begin_x,
   output logic signed [dss_pkg::COORD_W-1:0]  rsp_dash_begin_y,
   output logic signed [dss_pkg::COORD_W-1:0]  rsp_dash_begin_z,
   output logic signed [dss_pkg::COORD_W-1:0]  rsp_dash_end_x,
   output logic signed [dss_pkg::COORD_W-1:0]  rsp_dash_end_y,
   output logic signed [dss_pkg::COORD_W-1:0]  rsp_dash_end_z,
   output logic                                rsp_last_dash,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dss_pkg::IDX_W-1:0]           csr_index,
   input  logic [dss_pkg::CFG_W-1:0]           csr_data
);

   localparam int N_W = $clog2(MAX_DASHES + 1);
   localparam logic [24:0] EPS_RAW  = 25'(((1 << FRAC_BITS) + 9999) / 10000);
   localparam logic [24:0] HALF_RAW = 25'(1 << (FRAC_BITS - 1));

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SQ    = 4'd1;
   localparam logic [3:0] S_SQRT  = 4'd2;
   localparam logic [3:0] S_CHK   = 4'd3;
   localparam logic [3:0] S_MOD   = 4'd4;
   localparam logic [3:0] S_PH    = 4'd5;
   localparam logic [3:0] S_WALK  = 4'd6;
   localparam logic [3:0] S_DLOAD = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_PMUL  = 4'd9;
   localparam logic [3:0] S_PADD  = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [23:0] dl_ff, dl_in, dg_ff, dg_in;
   logic [31:0] base_ff [3];
   logic [31:0] base_in [3];
   logic [32:0] mag_ff [3];
   logic [32:0] mag_in [3];
   logic [2:0]  neg_ff, neg_in;
   logic [69:0] acc_ff, acc_in;
   logic [37:0] part_ff, part_in;
   logic [34:0] qt_ff, qt_in;
   logic [34:0] len_ff, len_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  idx_ff, idx_in;
   logic [24:0] sum_ff, sum_in;
   logic [24:0] ph_ff, ph_in;
   logic [24:0] seg_ff, seg_in;
   logic signed [35:0] rem_ff, rem_in;
   logic [34:0] t_ff, t_in;
   logic [34:0] tq_ff, tq_in;
   logic [N_W-1:0] n_ff, n_in;
   logic        endpt_ff, endpt_in;
   logic [65:0] prod_ff, prod_in;
   logic [31:0] pend_ff [6];
   logic [31:0] pend_in [6];
   logic        pend_v_ff, pend_v_in;
   logic        rv_ff, rv_in;
   logic        last_ff, last_in;

   // shared compare-subtract unit
   logic [37:0]       step_a, step_b;
   dss_pkg::step_type step;
   // shared multiplier
   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_p;

   logic [32:0] mag_sel;
   logic [31:0] base_sel;
   logic        neg_sel;
   logic [65:0] dividend;
   logic [65:0] rnd;
   logic signed [35:0] rem_chk;
   logic [24:0] sum_raw;
   logic        is_dash, emit, walk_done;
   logic [24:0] seg0, seg;
   logic [27:0] seg5;
   logic [2:0]  pend_idx;
   logic signed [32:0] dx [3];

   assign step.diff = {1'b0, step_a} - {1'b0, step_b};
   assign step.ge   = ~step.diff[38];
   assign mul_p     = mul_a * mul_b;

   always_comb begin
      case (idx_ff)
         2'd0:    begin mag_sel = mag_ff[0]; base_sel = base_ff[0]; neg_sel = neg_ff[0]; end
         2'd1:    begin mag_sel = mag_ff[1]; base_sel = base_ff[1]; neg_sel = neg_ff[1]; end
         default: begin mag_sel = mag_ff[2]; base_sel = base_ff[2]; neg_sel = neg_ff[2]; end
      endcase
   end

   assign dx[0] = 33'(req_finish_x) - 33'(req_start_x);
   assign dx[1] = 33'(req_finish_y) - 33'(req_start_y);
   assign dx[2] = 33'(req_finish_z) - 33'(req_start_z);

   assign dividend = {1'b0, tq_ff, 30'd0} + {32'd0, len_ff[34:1]};
   assign rnd      = prod_ff + 66'(1 << 29);
   assign rem_chk  = $signed({1'b0, len_ff}) - $signed({12'd0, dg_ff});
   assign sum_raw  = {1'b0, dl_ff} + {1'b0, dg_ff};
   assign pend_idx = {1'b0, idx_ff} + (endpt_ff ? 3'd3 : 3'd0);

   // one step of the dash walk
   assign walk_done = (rem_ff <= 36'sd0) || (n_ff == N_W'(MAX_DASHES));
   assign is_dash   = ph_ff < {1'b0, dl_ff};
   assign seg0      = is_dash ? ({1'b0, dl_ff} - ph_ff) : {1'b0, dg_ff};
   assign seg       = ($signed({11'd0, seg0}) > rem_ff) ? rem_ff[24:0] : seg0;
   assign seg5      = {1'b0, seg, 2'b00} + {3'b000, seg};
   assign emit      = is_dash && (seg5 > {4'd0, dl_ff});

   always_comb begin
      step_a = {part_ff[36:0], acc_ff[69]};
      step_b = {13'd0, sum_ff};
      mul_a  = mag_sel;
      mul_b  = {2'b00, qt_ff[30:0]};
      unique case (state_ff)
         S_SQRT: begin
            step_a = {part_ff[35:0], acc_ff[69:68]};
            step_b = {1'b0, qt_ff, 2'b01};
         end
         S_DIV:  step_b = {3'd0, len_ff};
         S_SQ:   mul_b  = mag_sel;
         default: ;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      dl_in     = dl_ff;
      dg_in     = dg_ff;
      base_in   = base_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      part_in   = part_ff;
      qt_in     = qt_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      ph_in     = ph_ff;
      seg_in    = seg_ff;
      rem_in    = rem_ff;
      t_in      = t_ff;
      tq_in     = tq_ff;
      n_in      = n_ff;
      endpt_in  = endpt_ff;
      prod_in   = prod_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      rv_in     = 1'b0;
      last_in   = 1'b0;

      if (csr_valid) begin
         if (csr_index == dss_pkg::CSR_DASH_LENGTH) dl_in = csr_data;
         else if (csr_index == dss_pkg::CSR_DASH_GAP) dg_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               base_in[0] = req_start_x;
               base_in[1] = req_start_y;
               base_in[2] = req_start_z;
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = dx[i][32];
                  mag_in[i] = dx[i][32] ? 33'(-dx[i]) : dx[i];
               end
               acc_in    = '0;
               idx_in    = 2'd0;
               pend_v_in = 1'b0;
               state_in  = S_SQ;
            end
         end
         S_SQ: begin
            acc_in = acc_ff + {4'd0, mul_p};
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               // pad radicand to 70 bits: 35 digit pairs
               part_in  = '0;
               qt_in    = '0;
               cnt_in   = 6'd34;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            acc_in = {acc_ff[67:0], 2'b00};
            if (step.ge) begin
               part_in = step.diff[37:0];
               qt_in   = {qt_ff[33:0], 1'b1};
            end else begin
               part_in = step_a;
               qt_in   = {qt_ff[33:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               len_in   = step.ge ? {qt_ff[33:0], 1'b1} : {qt_ff[33:0], 1'b0};
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            rem_in  = rem_chk;
            sum_in  = (sum_raw < EPS_RAW) ? HALF_RAW : sum_raw;
            part_in = '0;
            acc_in  = {len_ff[34:1], 36'd0};
            cnt_in  = 6'd33;
            if (dl_ff == '0 || rem_chk < $signed({11'd0, EPS_RAW})) state_in = S_IDLE;
            else state_in = S_MOD;
         end
         S_MOD: begin
            acc_in  = {acc_ff[68:0], 1'b0};
            part_in = step.ge ? step.diff[37:0] : step_a;
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_PH;
         end
         S_PH: begin
            ph_in    = sum_ff - part_ff[24:0];
            t_in     = {12'd0, dg_ff[23:1]};
            n_in     = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (walk_done) begin
               if (pend_v_ff) begin
                  rv_in   = 1'b1;
                  last_in = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               t_in   = t_ff + {10'd0, seg};
               rem_in = rem_ff - $signed({11'd0, seg});
               ph_in  = is_dash ? {1'b0, dl_ff} : '0;
               if (emit) begin
                  // previous dash is known not to be the last one now
                  rv_in     = pend_v_ff;
                  n_in      = n_ff + N_W'(1);
                  tq_in     = t_ff;
                  seg_in    = seg;
                  endpt_in  = 1'b0;
                  state_in  = S_DLOAD;
               end
            end
         end
         S_DLOAD: begin
            part_in  = {3'd0, dividend[65:31]};
            acc_in   = {dividend[30:0], 39'd0};
            qt_in    = '0;
            cnt_in   = 6'd30;
            state_in = S_DIV;
         end
         S_DIV: begin
            acc_in  = {acc_ff[68:0], 1'b0};
            part_in = step.ge ? step.diff[37:0] : step_a;
            qt_in   = {qt_ff[33:0], step.ge};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               idx_in   = 2'd0;
               state_in = S_PMUL;
            end
         end
         S_PMUL: begin
            prod_in  = mul_p;
            state_in = S_PADD;
         end
         S_PADD: begin
            pend_in[pend_idx] = neg_sel ? base_sel - rnd[61:30] : base_sel + rnd[61:30];
            idx_in   = idx_ff + 2'd1;
            state_in = S_PMUL;
            if (idx_ff == 2'd2) begin
               if (!endpt_ff) begin
                  endpt_in = 1'b1;
                  tq_in    = tq_ff + {10'd0, seg_ff};
                  state_in = S_DLOAD;
               end else begin
                  pend_v_in = 1'b1;
                  state_in  = S_WALK;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         dl_ff     <= dss_pkg::DASH_LENGTH_RST;
         dg_ff     <= dss_pkg::DASH_GAP_RST;
         pend_v_ff <= 1'b0;
         rv_ff     <= 1'b0;
         last_ff   <= 1'b0;
         n_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         dl_ff     <= dl_in;
         dg_ff     <= dg_in;
         pend_v_ff <= pend_v_in;
         rv_ff     <= rv_in;
         last_ff   <= last_in;
         n_ff      <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      part_ff  <= part_in;
      qt_ff    <= qt_in;
      len_ff   <= len_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      sum_ff   <= sum_in;
      ph_ff    <= ph_in;
      seg_ff   <= seg_in;
      rem_ff   <= rem_in;
      t_ff     <= t_in;
      tq_ff    <= tq_in;
      endpt_ff <= endpt_in;
      prod_ff  <= prod_in;
      pend_ff  <= pend_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rv_ff;
   assign rsp_last_dash    = last_ff;
   assign rsp_dash_begin_x = pend_ff[0];
   assign rsp_dash_begin_y = pend_ff[1];
   assign rsp_dash_begin_z = pend_ff[2];
   assign rsp_dash_end_x   = pend_ff[3];
   assign rsp_dash_end_y   = pend_ff[4];
   assign rsp_dash_end_z   = pend_ff[5];

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item accepted but block not busy");
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_dash |=> !rsp_valid)
      else $error("item emitted straight after final dash");
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_dash |-> busy)
      else $error("non-final dash emitted while idle");
   a_count: assert property (@(posedge clock) disable iff (reset)
      n_ff <= N_W'(MAX_DASHES))
      else $error("dash count over limit");
   a_emit_pend: assert property (@(posedge clock) disable iff (reset)
      rv_in |-> pend_v_ff)
      else $error("item emitted with no pending dash");

endmodule
